FILE: hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// S-box, GF(2^8) helpers and round transforms shared by the round cells.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxWidth = 1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef logic [127:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte n of the FIPS state sits at bits [127-8n -: 8]
  function automatic logic [7:0] get_byte(input blk_t s, input int unsigned n);
    get_byte = s[127-8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c+r)%4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      t[127-8*(4*c) -: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_columns = t;
  endfunction

  function automatic blk_t next_round_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

endpackage

FILE: hw/rtl/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES round cell
// One registered round: SubBytes, ShiftRows, optional MixColumns,
// AddRoundKey, and the next round key computed alongside.
// ----------------------------------------------------------------------------
module aes_round_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic              clk,
  input  logic              advance,
  input  logic [7:0]        rcon,
  input  aes_pkg::blk_t     state_in,
  input  aes_pkg::blk_t     key_in,
  output aes_pkg::blk_t     state_out,
  output aes_pkg::blk_t     key_out
);
  import aes_pkg::*;

  blk_t key_next;
  blk_t sub_next;
  blk_t mix_next;

  always_comb begin
    key_next = next_round_key(key_in, rcon);
    sub_next = sub_shift(state_in);
    mix_next = LastRound ? sub_next : mix_columns(sub_next);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_out <= mix_next ^ key_next;
      key_out   <= key_next;
    end
  end

endmodule

FILE: hw/rtl/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Ten-cell round pipeline, ECB, key from two configuration registers.
// ----------------------------------------------------------------------------
// Datapath: the accepting edge loads the input register, then the block
// passes through ten round cells and then the output register.
// Throughput: one block per cycle; the whole chain stalls only when the
// output register is full and not taken.
// Reset: rst clears the valid bits and the key registers to zero.
module aes128_block_encrypt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [aes_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [127:0]                    s_tdata,  // block_high, block_low
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [127:0]                    m_tdata   // cipher_high, cipher_low
);
  import aes_pkg::*;

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        advance;
  logic [NumRounds:0] vld;
  blk_t        st [NumRounds+1];
  blk_t        rk [NumRounds+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= {s_tdata[63:0], s_tdata[127:64]} ^ {key_high, key_low};
      rk[0] <= {key_high, key_low};
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round_cell #(
      .LastRound(g == NumRounds - 1)
    ) u_cell (
      .clk      (clk),
      .advance  (advance),
      .rcon     (RCON[g]),
      .state_in (st[g]),
      .key_in   (rk[g]),
      .state_out(st[g+1]),
      .key_out  (rk[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NumRounds-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= vld[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {st[NumRounds][63:0], st[NumRounds][127:64]};
    end
  end

endmodule
